// ===== rtl/core/fnvhm_pkg.sv =====
// Package for the FNV-1a linear probe hash map.
// Holds table sizes, FNV constants, status codes and field widths.
// No dependencies.
package fnvhm_pkg;

  localparam int TableEntries = 1024;
  localparam int SlotBits     = $clog2(TableEntries);
  localparam int KeyBytes     = 8;
  localparam int KeyBits      = 64;
  localparam int ValueBits    = 32;
  localparam int CountBits    = SlotBits + 1;
  localparam int MaxBits      = 10;
  localparam int StatusBits   = 3;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  localparam logic [StatusBits-1:0] StInserted = 3'd0;
  localparam logic [StatusBits-1:0] StUpdated  = 3'd1;
  localparam logic [StatusBits-1:0] StHit      = 3'd2;
  localparam logic [StatusBits-1:0] StMiss     = 3'd3;
  localparam logic [StatusBits-1:0] StFull     = 3'd4;

  localparam logic CmdSet = 1'b0;
  localparam logic CmdGet = 1'b1;

  typedef logic [SlotBits-1:0] slot_t;

endpackage

// ===== rtl/core/fnv1a_linear_probe_hash_map_top.sv =====
// Top level of the FNV-1a linear probe hash map.
// Hash sequencer, slot memories and probe walk; uses fnvhm_pkg.
//
// Channel   Dir  Signals                       Content
// s_axis    in   s_axis_tvalid/tready/tdata    one command beat
// m_axis    out  m_axis_tvalid/tready/tdata    one result beat
// cfg       in   cfg_we, cfg_wdata             max_entries
//
// A command hashes its key one byte at a time (one multiply per key byte,
// shared), then reads and compares each probed slot in SRead and SComp
// and hands its result out in SOut. Reset clears the count at once and
// starts a clearing pass over the occupied marks of all 1024 slots;
// no command is taken until the pass ends.
// The result register holds while m_axis_tready is low; no new command is
// taken until the result has left.
module fnv1a_linear_probe_hash_map_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from low: command[0], key[64:1], value[96:65], zero pad to 104.
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from low: status[2:0], read_value[34:3], zero pad to 40.
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [fnvhm_pkg::MaxBits-1:0] cfg_wdata
);
  import fnvhm_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SHash  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SComp  = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;
  localparam logic [2:0] SClear = 3'd5;

  logic [2:0]            state;
  logic                  cmd;
  logic [KeyBits-1:0]    key;
  logic [ValueBits-1:0]  val;
  logic [31:0]           hash;
  logic [2:0]            byte_idx;
  slot_t                 pos;
  logic [SlotBits:0]     probes;
  logic [CountBits-1:0]  entry_count;
  logic [MaxBits-1:0]    max_entries;
  logic                  slot_used [TableEntries];
  logic [KeyBits-1:0]    slot_key [TableEntries];
  logic [ValueBits-1:0]  slot_value [TableEntries];
  logic [KeyBits-1:0]    rd_key;
  logic [ValueBits-1:0]  rd_value;
  logic                  rd_used;
  logic [StatusBits-1:0] status;
  logic [ValueBits-1:0]  read_value;
  logic                  wr_en;
  logic                  wr_key_en;
  logic                  used_we;
  logic                  used_wdata;
  logic [63:0]           mul;
  logic [7:0]            cur_byte;

  assign s_axis_tready = (state == SIdle);
  assign m_axis_tvalid = (state == SOut);
  assign m_axis_tdata  = {5'd0, read_value, status};

  assign cur_byte = key[{byte_idx, 3'b000} +: 8];
  assign mul      = 64'((hash ^ {24'd0, cur_byte})) * 64'(FnvPrime);

  assign used_we    = (state == SClear) || wr_key_en;
  assign used_wdata = wr_key_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MaxBits'(717);
    end else if (cfg_we) begin
      max_entries <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      slot_key[pos] <= key;
    end
    if (wr_en) begin
      slot_value[pos] <= val;
    end
    if (used_we) begin
      slot_used[pos] <= used_wdata;
    end
    rd_key   <= slot_key[pos];
    rd_value <= slot_value[pos];
    rd_used  <= slot_used[pos];
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    if (state == SComp && cmd == CmdSet) begin
      if (!rd_used) begin
        wr_key_en = (CountBits'(entry_count) < CountBits'(max_entries));
        wr_en     = wr_key_en;
      end else if (rd_key == key) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SClear;
      pos         <= '0;
      entry_count <= '0;
    end else begin
      unique case (state)
        SClear: begin
          pos <= pos + 1'b1;
          if (pos == slot_t'(TableEntries - 1)) begin
            state <= SIdle;
          end
        end
        SIdle: begin
          if (s_axis_tvalid) begin
            cmd      <= s_axis_tdata[0];
            key      <= s_axis_tdata[64:1];
            val      <= s_axis_tdata[96:65];
            hash     <= FnvBasis;
            byte_idx <= '0;
            state    <= SHash;
          end
        end
        SHash: begin
          hash     <= mul[31:0];
          byte_idx <= byte_idx + 3'd1;
          if (byte_idx == 3'(KeyBytes - 1)) begin
            pos    <= mul[SlotBits-1:0];
            probes <= '0;
            state  <= SRead;
          end
        end
        SRead: begin
          state <= SComp;
        end
        SComp: begin
          read_value <= '0;
          if (!rd_used) begin
            if (wr_key_en) begin
              entry_count <= entry_count + 1'b1;
              status      <= StInserted;
            end else begin
              status <= (cmd == CmdSet) ? StFull : StMiss;
            end
            state <= SOut;
          end else if (rd_key == key) begin
            if (cmd == CmdSet) begin
              status <= StUpdated;
            end else begin
              status     <= StHit;
              read_value <= rd_value;
            end
            state <= SOut;
          end else if (probes == (SlotBits+1)'(TableEntries - 1)) begin
            status <= (cmd == CmdSet) ? StFull : StMiss;
            state  <= SOut;
          end else begin
            pos    <= pos + 1'b1;
            probes <= probes + 1'b1;
            state  <= SRead;
          end
        end
        SOut: begin
          if (m_axis_tready) begin
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CountBits'(TableEntries))
    else $error("entry count above table size");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status != StHit) |-> read_value == '0)
    else $error("nonzero read value without hit");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == SComp && wr_key_en) |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not bump count");

endmodule
